// ===== src/dts_pkg.sv =====
`timescale 1ns / 1ps

package dts_pkg;

   localparam int TYPE_W      = 3;
   localparam int DELTA_W     = 16;
   localparam int TTL_W       = 16;
   localparam int CREDIT_W    = 4;
   localparam int FAST_W      = 4;
   localparam int INTERVAL_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_TICK          = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_NEW_NEIGHBOR  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_LOCAL_CHANGE  = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_LINK_UP       = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LINK_DOWN     = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_SHUTDOWN      = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_SEND_FAILED   = 3'd6;

   // csr indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CREDIT_LIMIT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_SEND_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORMAL_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_INTERVAL   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TTL        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_ADDR_KNOWN  = 3'd5;

   // csr reset values
   localparam logic [CREDIT_W-1:0]   CREDIT_LIMIT_RST    = 4'd5;
   localparam logic [FAST_W-1:0]     FAST_SEND_COUNT_RST = 4'd4;
   localparam logic [INTERVAL_W-1:0] NORMAL_INTERVAL_RST = 16'd6;
   localparam logic [INTERVAL_W-1:0] FAST_INTERVAL_RST   = 16'd1;
   localparam logic [TTL_W-1:0]      HOLD_TTL_RST        = 16'd30;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic [CREDIT_W-1:0]   credit_limit;
      logic [FAST_W-1:0]     fast_send_count;
      logic [INTERVAL_W-1:0] normal_interval;
      logic [INTERVAL_W-1:0] fast_interval;
      logic [TTL_W-1:0]      hold_ttl;
      logic                  source_address_known;
   } cfg_type;

   // one queued send run: one or two frame requests with the same ttl
   typedef struct packed {
      logic [TTL_W-1:0] ttl;
      logic             two_sends;
   } entry_type;

endpackage

// ===== src/dts_front.sv =====
`timescale 1ns / 1ps

module dts_front (
   input  logic                          clock,
   input  logic                          reset,
   input  dts_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dts_pkg::TYPE_W-1:0]    req_type,
   input  logic [dts_pkg::DELTA_W-1:0]   req_delta_seconds,
   input  logic                          queue_full,
   output logic                          push,
   output dts_pkg::entry_type            push_entry
);
   import dts_pkg::*;

   typedef struct packed {
      logic [CREDIT_W-1:0]   credit;
      logic [INTERVAL_W-1:0] timer;
      logic [FAST_W-1:0]     fast;
      logic                  pend;
      logic                  link;
      logic [1:0]            sends;
   } sched_type;

   function automatic sched_type try_send(sched_type s, logic addr_known);
      sched_type r;
      r = s;
      if (r.pend && (r.credit != '0) && addr_known) begin
         r.pend   = 1'b0;
         r.credit = r.credit - CREDIT_W'(1);
         r.sends  = r.sends + 2'd1;
      end
      return r;
   endfunction

   function automatic sched_type trigger_send(sched_type s, cfg_type c);
      sched_type r;
      r = s;
      r.timer = (r.fast != '0) ? c.fast_interval : c.normal_interval;
      r.pend  = 1'b1;
      return try_send(r, c.source_address_known);
   endfunction

   function automatic sched_type timer_expiry(sched_type s, cfg_type c);
      sched_type r;
      r = s;
      if (r.fast != '0) begin
         r.fast = r.fast - FAST_W'(1);
      end
      return trigger_send(r, c);
   endfunction

   function automatic sched_type new_neighbor(sched_type s, cfg_type c);
      sched_type r;
      r = s;
      if (r.fast == '0) begin
         r.fast = c.fast_send_count;
      end
      return timer_expiry(r, c);
   endfunction

   logic [CREDIT_W-1:0]   credit_ff, credit_in;
   logic [INTERVAL_W-1:0] timer_ff, timer_in;
   logic [FAST_W-1:0]     fast_ff, fast_in;
   logic                  pend_ff, pend_in;
   logic                  link_ff, link_in;

   logic                  accept;
   logic                  shutdown_emit;
   sched_type             nxt;
   logic [DELTA_W:0]      credit_sum;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      nxt.credit    = credit_ff;
      nxt.timer     = timer_ff;
      nxt.fast      = fast_ff;
      nxt.pend      = pend_ff;
      nxt.link      = link_ff;
      nxt.sends     = 2'd0;
      shutdown_emit = 1'b0;
      credit_sum    = {{(DELTA_W+1-CREDIT_W){1'b0}}, credit_ff}
                    + {1'b0, req_delta_seconds};
      case (req_type)
         REQ_TICK: begin
            if (link_ff) begin
               if (credit_sum <= {{(DELTA_W+1-CREDIT_W){1'b0}}, cfg.credit_limit}) begin
                  nxt.credit = credit_sum[CREDIT_W-1:0];
               end
               if (timer_ff > req_delta_seconds) begin
                  nxt.timer = timer_ff - req_delta_seconds;
               end else begin
                  nxt.timer = '0;
                  nxt = timer_expiry(nxt, cfg);
               end
               nxt = try_send(nxt, cfg.source_address_known);
            end
         end
         REQ_NEW_NEIGHBOR: begin
            nxt = new_neighbor(nxt, cfg);
         end
         REQ_LOCAL_CHANGE: begin
            nxt = trigger_send(nxt, cfg);
         end
         REQ_LINK_UP: begin
            if (!link_ff) begin
               nxt = new_neighbor(nxt, cfg);
               nxt.link = 1'b1;
               nxt = trigger_send(nxt, cfg);
            end
         end
         REQ_LINK_DOWN: begin
            if (link_ff) begin
               nxt.link = 1'b0;
               nxt = trigger_send(nxt, cfg);
            end
         end
         REQ_SHUTDOWN: begin
            shutdown_emit = cfg.source_address_known;
         end
         REQ_SEND_FAILED: begin
            nxt.link = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign push                 = accept && ((nxt.sends != 2'd0) || shutdown_emit);
   assign push_entry.ttl       = shutdown_emit ? '0 : cfg.hold_ttl;
   assign push_entry.two_sends = (nxt.sends == 2'd2);

   assign credit_in = accept ? nxt.credit : credit_ff;
   assign timer_in  = accept ? nxt.timer  : timer_ff;
   assign fast_in   = accept ? nxt.fast   : fast_ff;
   assign pend_in   = accept ? nxt.pend   : pend_ff;
   assign link_in   = accept ? nxt.link   : link_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         timer_ff  <= '0;
         fast_ff   <= '0;
         pend_ff   <= 1'b0;
         link_ff   <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         timer_ff  <= timer_in;
         fast_ff   <= fast_in;
         pend_ff   <= pend_in;
         link_ff   <= link_in;
      end
   end

   // a tick on a down link leaves the scheduler untouched
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_TICK) && !link_ff)
      |=> ($stable(credit_ff) && $stable(timer_ff) && $stable(fast_ff) && $stable(pend_ff)))
      else $error("tick changed state while link down");

endmodule

// ===== src/dts_queue.sv =====
`timescale 1ns / 1ps

module dts_queue #(
   parameter int DEPTH = dts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dts_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output dts_pkg::entry_type head_entry
);
   import dts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with pointers apart");

   assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

// ===== src/dts_back.sv =====
`timescale 1ns / 1ps

module dts_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  dts_pkg::entry_type           head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dts_pkg::TTL_W-1:0]    rsp_frame_ttl,
   output logic                         rsp_last_of_run
);
   import dts_pkg::*;

   logic             valid_ff, valid_in;
   logic             second_ff, second_in;
   logic [TTL_W-1:0] ttl_ff, ttl_in;
   logic             last_ff, last_in;
   logic             out_free;

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = out_free && !second_ff && head_valid;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      ttl_in    = ttl_ff;
      last_in   = last_ff;
      if (out_free) begin
         if (second_ff) begin
            // second send of a run repeats the ttl and closes it
            valid_in  = 1'b1;
            last_in   = 1'b1;
            second_in = 1'b0;
         end else if (head_valid) begin
            valid_in  = 1'b1;
            ttl_in    = head_entry.ttl;
            last_in   = !head_entry.two_sends;
            second_in = head_entry.two_sends;
         end else begin
            valid_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      ttl_ff  <= ttl_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_frame_ttl   = ttl_ff;
   assign rsp_last_of_run = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (valid_ff && !last_ff))
      else $error("second send pending without open first send");

endmodule

// ===== src/discovery_transmit_scheduler_core.sv =====
`timescale 1ns / 1ps

// Credit-bucket scheduler for link-discovery announcements. Each request
// transaction is one event (tick, new neighbor, local change, link up/down,
// shutdown, send failed); it updates the credit count, interval timer,
// fast-transmit counter, pending flag and link flag in the cycle it is taken,
// and may give zero, one or two response transactions, each a frame request
// with its time to live, the last one of an event marked by rsp_last_of_run.
// A request is taken every cycle while the internal queue has room; the first
// response of an event passes the queue and then the response register, which
// sends one frame request per cycle while rsp_ready is high; an event that gives
// two requests holds it for both. The user writes registers through the csr port
// only while no event is in flight; the block itself does not enforce this.

module discovery_transmit_scheduler_core #(
   parameter int QUEUE_DEPTH = dts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_wr_en,
   input  logic [dts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dts_pkg::CSR_DATA_W-1:0]    csr_wdata,
   // event transactions
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dts_pkg::TYPE_W-1:0]        req_type,
   input  logic [dts_pkg::DELTA_W-1:0]       req_delta_seconds,
   // frame request transactions
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dts_pkg::TTL_W-1:0]         rsp_frame_ttl,
   output logic                              rsp_last_of_run
);
   import dts_pkg::*;

   // configuration registers
   logic [CREDIT_W-1:0]   credit_limit_ff;
   logic [FAST_W-1:0]     fast_send_count_ff;
   logic [INTERVAL_W-1:0] normal_interval_ff;
   logic [INTERVAL_W-1:0] fast_interval_ff;
   logic [TTL_W-1:0]      hold_ttl_ff;
   logic                  src_addr_known_ff;

   cfg_type   cfg;
   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_limit_ff    <= CREDIT_LIMIT_RST;
         fast_send_count_ff <= FAST_SEND_COUNT_RST;
         normal_interval_ff <= NORMAL_INTERVAL_RST;
         fast_interval_ff   <= FAST_INTERVAL_RST;
         hold_ttl_ff        <= HOLD_TTL_RST;
         src_addr_known_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CREDIT_LIMIT:    credit_limit_ff    <= csr_wdata[CREDIT_W-1:0];
            CSR_FAST_SEND_COUNT: fast_send_count_ff <= csr_wdata[FAST_W-1:0];
            CSR_NORMAL_INTERVAL: normal_interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_FAST_INTERVAL:   fast_interval_ff   <= csr_wdata[INTERVAL_W-1:0];
            CSR_HOLD_TTL:        hold_ttl_ff        <= csr_wdata[TTL_W-1:0];
            CSR_SRC_ADDR_KNOWN:  src_addr_known_ff  <= csr_wdata[0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   assign cfg.credit_limit         = credit_limit_ff;
   assign cfg.fast_send_count      = fast_send_count_ff;
   assign cfg.normal_interval      = normal_interval_ff;
   assign cfg.fast_interval        = fast_interval_ff;
   assign cfg.hold_ttl             = hold_ttl_ff;
   assign cfg.source_address_known = src_addr_known_ff;

   // front: takes events, runs the scheduler state, produces send runs
   dts_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_delta_seconds (req_delta_seconds),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   // short queue so a stalled response side does not block events at once
   dts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: splits each run into frame request transactions
   dts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_ttl   (rsp_frame_ttl),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // a popped run always lands in the response register next cycle
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped run not presented");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dts_pkg::*;

   // request code the block has no meaning for, it must be dropped quietly
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
   // a directed row whose outcome comes from the predictor
   localparam int PREDICTED = -1;
   // cycles to let a request that gives no frame clear the pipeline
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASES = 6;
   localparam int EVENTS_PER_PHASE = 250;

   typedef enum logic {ROW_EVENT, ROW_CSR} row_kind_type;

   // one line of the directed script: an event transaction or a csr write
   typedef struct {
      row_kind_type     kind;
      logic [2:0]       code;      // request code or csr index
      logic [15:0]      value;     // delta seconds or csr data
      int               n_typed;   // frames typed in, or PREDICTED
      logic [TTL_W-1:0] ttl;
   } row_type;

   typedef struct {
      logic [TTL_W-1:0] ttl;
      logic             last;
   } frame_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TYPE_W-1:0]      req_type = '0;
   logic [DELTA_W-1:0]     req_delta_seconds = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TTL_W-1:0]       rsp_frame_ttl;
   logic                   rsp_last_of_run;

   // no_idle turns off the random gaps on both sides for one phase
   logic no_idle = 1'b0;

   frame_type        frames_due[$];   // frame requests still owed by the block
   logic [TTL_W-1:0] run_ttl[$];      // frames caused by the event being predicted

   // scheduler state as the block should hold it
   cfg_type       cfg;
   logic [3:0]    credit;
   logic [3:0]    fast_left;
   logic [15:0]   timer;
   logic          send_armed;
   logic          link_up;

   int fail_count = 0;
   int frames_checked = 0;
   int double_runs = 0;
   int events_seen[8];

   row_type script [0:21] = '{
      // address unknown after reset: nothing may go out
      '{ROW_EVENT, REQ_SHUTDOWN,     16'd0,     0,         16'd0},
      '{ROW_EVENT, REQ_TICK,         16'hffff,  0,         16'd0},  // link still down
      '{ROW_EVENT, REQ_LINK_UP,      16'd0,     0,         16'd0},
      '{ROW_EVENT, REQ_LINK_UP,      16'hffff,  0,         16'd0},  // already up
      '{ROW_EVENT, REQ_UNUSED,       16'h5a5a,  0,         16'd0},
      '{ROW_CSR,   CSR_SRC_ADDR_KNOWN, 16'd1,   PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_SHUTDOWN,     16'hffff,  1,         16'd0},
      // refill refused, timer runs out, but no credit yet
      '{ROW_EVENT, REQ_TICK,         16'hffff,  PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_TICK,         16'd3,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_NEW_NEIGHBOR, 16'd0,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_NEW_NEIGHBOR, 16'd0,     PREDICTED, 16'd0},  // fast sends left
      '{ROW_EVENT, REQ_TICK,         16'd2,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_LOCAL_CHANGE, 16'd0,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_TICK,         16'd0,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_TICK,         16'd5,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_LINK_DOWN,    16'd0,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_LINK_DOWN,    16'd0,     PREDICTED, 16'd0},  // already down
      '{ROW_EVENT, REQ_LINK_UP,      16'd0,     PREDICTED, 16'd0},  // may give two
      '{ROW_EVENT, REQ_SEND_FAILED,  16'd0,     PREDICTED, 16'd0},
      '{ROW_EVENT, REQ_TICK,         16'h8000,  PREDICTED, 16'd0},  // down, no effect
      '{ROW_EVENT, REQ_SHUTDOWN,     16'd0,     1,         16'd0},
      '{ROW_EVENT, REQ_UNUSED,       16'hffff,  0,         16'd0}
   };

   discovery_transmit_scheduler_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_delta_seconds (req_delta_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_ttl     (rsp_frame_ttl),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // scheduler predictor
   // ---------------------------------------------------------------

   task automatic queue_frame(input logic [TTL_W-1:0] ttl);
      if (run_ttl.size() < 2)
         run_ttl.push_back(ttl);
   endtask

   // a pending send leaves only with a credit and a known address
   task automatic spend_credit();
      if (send_armed && credit != 0 && cfg.source_address_known) begin
         send_armed = 1'b0;
         credit = credit - 4'd1;
         queue_frame(cfg.hold_ttl);
      end
   endtask

   task automatic arm_send();
      timer = (fast_left != 0) ? cfg.fast_interval : cfg.normal_interval;
      send_armed = 1'b1;
      spend_credit();
   endtask

   task automatic expire_timer();
      if (fast_left != 0)
         fast_left = fast_left - 4'd1;
      arm_send();
   endtask

   // fast sends are armed only when none remain, then one is counted off at once and a send armed
   task automatic greet_neighbor();
      if (fast_left == 0)
         fast_left = cfg.fast_send_count;
      expire_timer();
   endtask

   task automatic predict_event(input logic [2:0] code, input logic [15:0] delta);
      run_ttl.delete();
      case (code)
         REQ_TICK: begin
            if (link_up) begin
               // refill only when the whole delta fits under the limit
               if (int'(credit) + int'(delta) <= int'(cfg.credit_limit))
                  credit = credit + delta[3:0];
               if (timer > delta) begin
                  timer = timer - delta;
               end else begin
                  timer = '0;
                  expire_timer();
               end
               spend_credit();
            end
         end
         REQ_NEW_NEIGHBOR: greet_neighbor();
         REQ_LOCAL_CHANGE: arm_send();
         REQ_LINK_UP: begin
            if (!link_up) begin
               greet_neighbor();
               link_up = 1'b1;
               arm_send();
            end
         end
         REQ_LINK_DOWN: begin
            if (link_up) begin
               link_up = 1'b0;
               arm_send();
            end
         end
         REQ_SHUTDOWN: begin
            if (cfg.source_address_known)
               queue_frame('0);
         end
         REQ_SEND_FAILED: link_up = 1'b0;
         default: ;
      endcase
   endtask

   task automatic push_predicted();
      for (int i = 0; i < run_ttl.size(); i++)
         frames_due.push_back('{run_ttl[i], i == run_ttl.size() - 1});
      if (run_ttl.size() == 2)
         double_runs++;
   endtask

   // ---------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------

   // random ready with the same idle rate as the sender
   always @(posedge clock)
      rsp_ready <= no_idle || ($urandom_range(99) >= 34);

   // one event transaction; returns in the step where it was taken, already predicted
   task automatic send_event(input logic [2:0] code, input logic [15:0] delta);
      if (!no_idle) begin
         while ($urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_type          <= code;
      req_delta_seconds <= delta;
      do @(posedge clock); while (!req_ready);
      events_seen[code]++;
      predict_event(code, delta);
   endtask

   // stop sending and let every owed frame and any silent event clear out
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (frames_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_wr_en high, the caller lowers it after its last write
   task automatic write_csr(input logic [2:0] index, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         CSR_CREDIT_LIMIT:    cfg.credit_limit = data[3:0];
         CSR_FAST_SEND_COUNT: cfg.fast_send_count = data[3:0];
         CSR_NORMAL_INTERVAL: cfg.normal_interval = data;
         CSR_FAST_INTERVAL:   cfg.fast_interval = data;
         CSR_HOLD_TTL:        cfg.hold_ttl = data;
         CSR_SRC_ADDR_KNOWN:  cfg.source_address_known = data[0];
         default: ;
      endcase
   endtask

   task automatic configure(input cfg_type c);
      drain();
      write_csr(CSR_CREDIT_LIMIT, 16'(c.credit_limit));
      write_csr(CSR_FAST_SEND_COUNT, 16'(c.fast_send_count));
      write_csr(CSR_NORMAL_INTERVAL, c.normal_interval);
      write_csr(CSR_FAST_INTERVAL, c.fast_interval);
      write_csr(CSR_HOLD_TTL, c.hold_ttl);
      write_csr(CSR_SRC_ADDR_KNOWN, 16'(c.source_address_known));
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // response checker: every frame request against the oldest owed one
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frames_due.size() == 0) begin
            $error("unexpected frame request: frame_ttl %0d, last_of_run %0b",
                   rsp_frame_ttl, rsp_last_of_run);
            fail_count++;
         end else begin
            want = frames_due.pop_front();
            frames_checked++;
            if (rsp_frame_ttl !== want.ttl) begin
               $error("frame_ttl: expected %0d, actual %0d", want.ttl, rsp_frame_ttl);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0b, actual %0b", want.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   initial begin
      cfg_type     c;
      logic [2:0]  code;
      logic [15:0] delta;
      int          roll;

      cfg = '{CREDIT_LIMIT_RST, FAST_SEND_COUNT_RST, NORMAL_INTERVAL_RST,
              FAST_INTERVAL_RST, HOLD_TTL_RST, 1'b0};
      credit = '0;
      fast_left = '0;
      timer = '0;
      send_armed = 1'b0;
      link_up = 1'b0;
      for (int i = 0; i < 8; i++)
         events_seen[i] = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script at reset settings, apart from the source address write
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            drain();
            write_csr(script[i].code, script[i].value);
            csr_wr_en <= 1'b0;
         end else begin
            send_event(script[i].code, script[i].value);
            if (script[i].n_typed == PREDICTED) begin
               push_predicted();
            end else begin
               for (int j = 0; j < script[i].n_typed; j++)
                  frames_due.push_back('{script[i].ttl, j == script[i].n_typed - 1});
            end
         end
      end

      // random phases, each under its own settings
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: c = '{4'd15, 4'd15, 16'hffff, 16'd1, 16'hffff, 1'b1};
            1: c = '{4'd1, 4'd1, 16'd1, 16'hffff, 16'd0, 1'b1};
            default: begin
               c.credit_limit = 4'($urandom_range(1, 15));
               c.fast_send_count = 4'($urandom_range(1, 15));
               c.normal_interval = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                                           : 16'($urandom_range(1, 8));
               c.fast_interval = 16'($urandom_range(1, 4));
               c.hold_ttl = 16'($urandom);
               // one phase with the address missing, so no frames are owed
               c.source_address_known = (p != 3);
            end
         endcase
         configure(c);
         // one phase runs flat out on both sides
         no_idle <= (p == 4);

         for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            if (roll < 48)      code = REQ_TICK;
            else if (roll < 58) code = REQ_NEW_NEIGHBOR;
            else if (roll < 68) code = REQ_LOCAL_CHANGE;
            else if (roll < 79) code = REQ_LINK_UP;
            else if (roll < 84) code = REQ_LINK_DOWN;
            else if (roll < 90) code = REQ_SHUTDOWN;
            else if (roll < 96) code = REQ_SEND_FAILED;
            else                code = REQ_UNUSED;

            // mostly small deltas so the bucket refills, some that overflow it
            roll = $urandom_range(99);
            if (code != REQ_TICK) delta = 16'($urandom);
            else if (roll < 60)   delta = 16'($urandom_range(0, 3));
            else if (roll < 85)   delta = 16'($urandom_range(0, 24));
            else                  delta = 16'($urandom);

            // now and then hold off until the block has caught up
            if ($urandom_range(99) == 0) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (frames_due.size() != 0);
            end

            send_event(code, delta);
            push_predicted();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (frames_due.size() != 0);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("covered %0d events (%0d ticks, %0d link up, %0d shutdown, %0d unused codes)",
               events_seen.sum(), events_seen[REQ_TICK], events_seen[REQ_LINK_UP],
               events_seen[REQ_SHUTDOWN], events_seen[REQ_UNUSED]);
      $display("checked %0d frame requests over %0d settings, %0d events gave two frames",
               frames_checked, PHASES + 1, double_runs);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #(2_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
src/dts_pkg.sv
src/dts_front.sv
src/dts_queue.sv
src/dts_back.sv
src/discovery_transmit_scheduler_core.sv
verif/tb.sv
